/* rtl/core/eue_pkg.sv */
// Package: types, status codes and decode helpers for the unwind engine.
`timescale 1ns / 1ps
package eue_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_BEGIN  = 2'd1,
    CMD_OPCODE = 2'd2,
    CMD_SUPPLY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_READ   = 3'd1,
    ST_DONE   = 3'd2,
    ST_REFUSE = 3'd3,
    ST_SEQ    = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  reg_index;
    logic [31:0] value;
    logic [7:0]  opcode_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_address;
    logic [31:0] frame_pc;
    logic [31:0] frame_sp;
    logic [31:0] reg_value;
  } result_t;

  localparam logic [31:0] HDR_MASK  = 32'hff000000;
  localparam logic [31:0] HDR_SHORT = 32'h80000000;
  localparam logic [31:0] HDR_LONG  = 32'h81000000;
  localparam logic [31:0] VSP_LARGE = 32'h00000204;

  function automatic logic [3:0] lowest_bit(input logic [15:0] m);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) r = 4'(i);
    end
    return r;
  endfunction

endpackage

/* rtl/core/eue_stream_if.sv */
// Valid/ready channel interface carrying one payload.
`timescale 1ns / 1ps
interface eue_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/eue_exec.sv */
// Single-pass executor: state registers and next-state for one accepted beat.
`timescale 1ns / 1ps
module eue_exec (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  eue_pkg::item_t   item,
  output eue_pkg::result_t res
);
  import eue_pkg::*;

  logic [31:0] regs [16];
  logic [9:0]  bytes_left;
  logic [7:0]  pend_byte;
  logic        pend_valid;
  logic [15:0] pop_mask;
  logic [31:0] pop_ptr;
  logic        pop_keeps_sp;
  logic        frame_active;

  logic [31:0] regs_next [16];
  logic [9:0]  bytes_left_next;
  logic [7:0]  pend_byte_next;
  logic        pend_valid_next;
  logic [15:0] pop_mask_next;
  logic [31:0] pop_ptr_next;
  logic        pop_keeps_sp_next;
  logic        frame_active_next;
  status_t     st;

  logic [7:0]  b;
  logic [7:0]  f;
  logic [31:0] sp;
  logic [11:0] m12;
  logic [15:0] amask;
  logic [3:0]  lb;
  logic        do_end;
  logic        do_refuse;
  logic        do_pop;
  logic [15:0] pmask;

  always_comb begin
    for (int i = 0; i < 16; i++) regs_next[i] = regs[i];
    bytes_left_next   = bytes_left;
    pend_byte_next    = pend_byte;
    pend_valid_next   = pend_valid;
    pop_mask_next     = pop_mask;
    pop_ptr_next      = pop_ptr;
    pop_keeps_sp_next = pop_keeps_sp;
    frame_active_next = frame_active;
    st        = ST_OK;
    b         = item.opcode_byte;
    f         = pend_byte;
    sp        = regs[13];
    m12       = {f[3:0], b};
    amask     = (16'(({1'b0, 8'hff} >> (3'd7 - b[2:0]))) << 4) | {1'b0, b[3], 14'd0};
    lb        = lowest_bit(pop_mask);
    do_end    = 1'b0;
    do_refuse = 1'b0;
    do_pop    = 1'b0;
    pmask     = 16'd0;
    case (cmd_t'(item.command))
      CMD_WRITE: regs_next[item.reg_index] = item.value;
      CMD_BEGIN: begin
        pend_valid_next = 1'b0;
        pend_byte_next  = 8'd0;
        pop_mask_next   = 16'd0;
        if ((item.value & HDR_MASK) == HDR_SHORT) begin
          bytes_left_next = 10'd3;
        end else if ((item.value & HDR_MASK) == HDR_LONG) begin
          bytes_left_next = {item.value[23:16], 2'b00} + 10'd2;
        end else begin
          bytes_left_next   = 10'd0;
          frame_active_next = 1'b0;
          st = ST_REFUSE;
        end
        if (st == ST_OK) begin
          regs_next[15]     = 32'd0;
          frame_active_next = 1'b1;
        end
      end
      CMD_OPCODE: begin
        if (!frame_active || pop_mask != 16'd0) begin
          st = ST_SEQ;
        end else begin
          if (bytes_left != 10'd0) bytes_left_next = bytes_left - 10'd1;
          if (pend_valid) begin
            pend_valid_next = 1'b0;
            pend_byte_next  = 8'd0;
            if (f[7:4] == 4'h8) begin
              if (m12 == 12'd0) do_refuse = 1'b1;
              else begin
                do_pop = 1'b1;
                pmask  = {m12, 4'd0};
              end
            end else if (f == 8'hb1) begin
              if (b == 8'd0 || b[7:4] != 4'd0) do_refuse = 1'b1;
              else begin
                do_pop = 1'b1;
                pmask  = {8'd0, b};
              end
            end else if (f == 8'hb2) begin
              regs_next[13] = sp + VSP_LARGE + {22'd0, b, 2'b00};
              do_end = 1'b1;
            end else if (f == 8'hb3) begin
              regs_next[13] = sp + {25'd0, b[3:0], 3'b000} + 32'd12;
              do_end = 1'b1;
            end else begin
              regs_next[13] = sp + {25'd0, b[3:0], 3'b000} + 32'd8;
              do_end = 1'b1;
            end
          end else begin
            if (b[7:6] == 2'b00) begin
              regs_next[13] = sp + {24'd0, b[5:0], 2'b00} + 32'd4;
              do_end = 1'b1;
            end else if (b[7:6] == 2'b01) begin
              regs_next[13] = sp - ({24'd0, b[5:0], 2'b00} + 32'd4);
              do_end = 1'b1;
            end else if (b[7:4] == 4'h8 || b == 8'hb1 || b == 8'hb2 || b == 8'hb3 ||
                         b == 8'hc8 || b == 8'hc9) begin
              if (bytes_left_next == 10'd0) do_refuse = 1'b1;
              else begin
                pend_byte_next  = b;
                pend_valid_next = 1'b1;
              end
            end else if (b == 8'h9d || b == 8'h9f) begin
              do_end = 1'b1;
            end else if (b[7:4] == 4'h9) begin
              regs_next[13] = regs[b[3:0]];
              do_end = 1'b1;
            end else if (b[7:4] == 4'ha) begin
              do_pop = 1'b1;
              pmask  = amask;
            end else if (b == 8'hb0) begin
              bytes_left_next = 10'd0;
              do_end = 1'b1;
            end else if (b[7:3] == 5'b10111) begin
              regs_next[13] = sp + {26'd0, b[2:0], 3'b000} + 32'd12;
              do_end = 1'b1;
            end else if (b[7:3] == 5'b11010) begin
              regs_next[13] = sp + {26'd0, b[2:0], 3'b000} + 32'd8;
              do_end = 1'b1;
            end else begin
              do_refuse = 1'b1;
            end
          end
        end
      end
      default: begin
        if (pop_mask == 16'd0) begin
          st = ST_SEQ;
        end else begin
          regs_next[lb] = item.value;
          pop_mask_next = pop_mask & ~(16'd1 << lb);
          pop_ptr_next  = pop_ptr + 32'd4;
          if (pop_mask_next != 16'd0) st = ST_READ;
          else begin
            if (!pop_keeps_sp) regs_next[13] = pop_ptr_next;
            do_end = 1'b1;
          end
        end
      end
    endcase
    // bytes_left check for a truncated two-byte opcode uses the count after decrement
    if (do_refuse) begin
      frame_active_next = 1'b0;
      pend_valid_next   = 1'b0;
      pend_byte_next    = 8'd0;
      pop_mask_next     = 16'd0;
      st = ST_REFUSE;
    end else if (do_pop) begin
      pop_mask_next     = pmask;
      pop_ptr_next      = regs_next[13];
      pop_keeps_sp_next = pmask[13];
      st = ST_READ;
    end else if (do_end) begin
      if (bytes_left_next == 10'd0) begin
        if (regs_next[15] == 32'd0) regs_next[15] = regs_next[14];
        frame_active_next = 1'b0;
        st = ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) regs[i] <= 32'd0;
      bytes_left   <= 10'd0;
      pend_byte    <= 8'd0;
      pend_valid   <= 1'b0;
      pop_mask     <= 16'd0;
      pop_ptr      <= 32'd0;
      pop_keeps_sp <= 1'b0;
      frame_active <= 1'b0;
    end else if (fire) begin
      for (int i = 0; i < 16; i++) regs[i] <= regs_next[i];
      bytes_left   <= bytes_left_next;
      pend_byte    <= pend_byte_next;
      pend_valid   <= pend_valid_next;
      pop_mask     <= pop_mask_next;
      pop_ptr      <= pop_ptr_next;
      pop_keeps_sp <= pop_keeps_sp_next;
      frame_active <= frame_active_next;
    end
  end

  always_comb begin
    res.status       = st;
    res.read_address = (st == ST_READ) ? pop_ptr_next : 32'd0;
    res.frame_pc     = regs_next[15];
    res.frame_sp     = regs_next[13];
    res.reg_value    = regs_next[item.reg_index];
  end
endmodule

/* rtl/core/ehabi_unwind_bytecode_engine.sv */
// Top level of the EHABI unwind bytecode engine.
`timescale 1ns / 1ps
// Usage:
//   in_ch carries one beat per command: register write, frame begin, opcode
//   byte or popped stack word. out_ch returns exactly one result beat per
//   input beat: status, read address, PC, SP and the register named by
//   reg_index as it stands after that beat.
//   A status of read request asks for the stack word at read_address; send it
//   back as a supply beat. Opcode beats during a pop are out of sequence.
//   Every input beat is executed in the cycle it is accepted by one pass of
//   decode, a lowest-set-bit pick and the adders; the result is registered,
//   and throughput is one beat per cycle while out_ch keeps taking results.
//   The result register is a single stage: a new beat is taken when that
//   stage is empty or being drained this cycle. A stalled receiver holds the
//   result and back-pressures the input after one beat.
//   Synchronous reset clears all sixteen registers, the byte count, the
//   pending byte, the pop state and the frame flag, and empties the output.
module ehabi_unwind_bytecode_engine (
  input logic         clk,
  input logic         rst,
  eue_stream_if.sink   in_ch,
  eue_stream_if.source out_ch
);
  import eue_pkg::*;

  logic    fire;
  result_t res;
  result_t out_data;
  logic    out_valid;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  eue_exec u_exec (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (in_ch.data),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data <= res;
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
endmodule

/* test/ehabi_unwind_bytecode_engine_tb.sv */
// Testbench for the unwind bytecode engine: random and directed beats checked against a predictor.
`timescale 1ns / 1ps
module ehabi_unwind_bytecode_engine_tb;
  import eue_pkg::*;

  class unwind_scoreboard;
    logic [31:0] regs [16];
    logic [9:0]  bytes_left;
    logic [7:0]  pend_byte;
    bit          pend_valid;
    logic [15:0] mask_left;
    logic [31:0] pop_ptr;
    bit          keeps_sp;
    bit          active;
    result_t     expected_q[$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      bytes_left = '0; pend_byte = '0; pend_valid = 0; mask_left = '0;
      pop_ptr = '0; keeps_sp = 0; active = 0; mismatches = 0;
    endfunction

    function status_t refuse();
      active = 0; pend_valid = 0; pend_byte = '0; mask_left = '0;
      return ST_REFUSE;
    endfunction

    function status_t finish_or_go();
      if (bytes_left != 0) return ST_OK;
      if (regs[15] == 0) regs[15] = regs[14];
      active = 0;
      return ST_DONE;
    endfunction

    function status_t begin_pop(logic [15:0] m);
      mask_left = m; pop_ptr = regs[13]; keeps_sp = m[13];
      return ST_READ;
    endfunction

    function status_t lead_byte(logic [7:0] b);
      logic [15:0] m;
      if (b[7:6] == 2'b00) regs[13] += {b[5:0], 2'b00} + 32'd4;
      else if (b[7:6] == 2'b01) regs[13] -= {b[5:0], 2'b00} + 32'd4;
      else if (b[7:4] == 4'h8 || b == 8'hb1 || b == 8'hb2 || b == 8'hb3 ||
               b == 8'hc8 || b == 8'hc9) begin
        if (bytes_left == 0) return refuse();
        pend_byte = b; pend_valid = 1;
        return ST_OK;
      end else if (b == 8'h9d || b == 8'h9f) begin
      end else if (b[7:4] == 4'h9) regs[13] = regs[b[3:0]];
      else if (b[7:4] == 4'ha) begin
        m = ((16'd1 << (b[2:0] + 1)) - 16'd1) << 4;
        if (b[3]) m[14] = 1'b1;
        return begin_pop(m);
      end else if (b == 8'hb0) bytes_left = '0;
      else if (b[7:3] == 5'b10111) regs[13] += 32'd4 * (2 * (b[2:0] + 1) + 1);
      else if (b[7:3] == 5'b11010) regs[13] += 32'd8 * (b[2:0] + 1);
      else return refuse();
      return finish_or_go();
    endfunction

    function status_t tail_byte(logic [7:0] f, logic [7:0] b);
      logic [11:0] m;
      pend_valid = 0; pend_byte = '0;
      if (f[7:4] == 4'h8) begin
        m = {f[3:0], b};
        if (m == 0) return refuse();
        return begin_pop({m, 4'h0});
      end else if (f == 8'hb1) begin
        if (b == 0 || b[7:4] != 0) return refuse();
        return begin_pop({8'h00, b});
      end else if (f == 8'hb2) regs[13] += VSP_LARGE + {22'd0, b, 2'b00};
      else if (f == 8'hb3) regs[13] += 32'd4 * (2 * (b[3:0] + 1) + 1);
      else regs[13] += 32'd8 * (b[3:0] + 1);
      return finish_or_go();
    endfunction

    function void note_item(item_t it);
      status_t st;
      int r;
      result_t res;
      st = ST_OK;
      case (cmd_t'(it.command))
        CMD_WRITE: regs[it.reg_index] = it.value;
        CMD_BEGIN: begin
          pend_valid = 0; pend_byte = '0; mask_left = '0;
          if ((it.value & HDR_MASK) == HDR_SHORT) bytes_left = 10'd3;
          else if ((it.value & HDR_MASK) == HDR_LONG)
            bytes_left = 10'(4 * it.value[23:16] + 2);
          else begin
            bytes_left = '0; active = 0; st = ST_REFUSE;
          end
          if (st == ST_OK) begin
            regs[15] = '0; active = 1;
          end
        end
        CMD_OPCODE: begin
          if (!active || mask_left != 0) st = ST_SEQ;
          else begin
            if (bytes_left != 0) bytes_left--;
            st = pend_valid ? tail_byte(pend_byte, it.opcode_byte)
                            : lead_byte(it.opcode_byte);
          end
        end
        default: begin
          if (mask_left == 0) st = ST_SEQ;
          else begin
            r = 0;
            while (!mask_left[r]) r++;
            regs[r] = it.value;
            mask_left[r] = 1'b0;
            pop_ptr += 32'd4;
            if (mask_left != 0) st = ST_READ;
            else begin
              if (!keeps_sp) regs[13] = pop_ptr;
              st = finish_or_go();
            end
          end
        end
      endcase
      res.status = st;
      res.read_address = (st == ST_READ) ? pop_ptr : '0;
      res.frame_pc = regs[15];
      res.frame_sp = regs[13];
      res.reg_value = regs[it.reg_index];
      expected_q.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = expected_q.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp st=%0d ra=%h pc=%h sp=%h rv=%h",
                    "  got st=%0d ra=%h pc=%h sp=%h rv=%h"},
                   exp.status, exp.read_address, exp.frame_pc, exp.frame_sp,
                   exp.reg_value, got.status, got.read_address, got.frame_pc,
                   got.frame_sp, got.reg_value);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  eue_stream_if #(.payload_t(item_t))   in_ch ();
  eue_stream_if #(.payload_t(result_t)) out_ch ();

  ehabi_unwind_bytecode_engine dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  unwind_scoreboard sb = new();
  int src_idle_pct = 24;
  int snk_idle_pct = 84;
  int sent = 0;
  int cycles = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("ehabi_unwind_bytecode_engine_tb: errors");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

  always @(negedge clk)
    out_ch.ready <= !rst && ($urandom_range(99) >= snk_idle_pct);

  task automatic send(logic [1:0] cmd, logic [3:0] idx, logic [31:0] val, logic [7:0] ob);
    item_t it;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    it.command = cmd; it.reg_index = idx; it.value = val; it.opcode_byte = ob;
    in_ch.data <= it;
    in_ch.valid <= 1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic op(logic [7:0] b);
    send(CMD_OPCODE, 4'($urandom), $urandom, b);
  endtask

  // answer pending pops until the predictor has no mask left
  task automatic drain_pop();
    while (sb.mask_left != 0) send(CMD_SUPPLY, 4'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic quiesce();
    in_ch.valid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_opcode();
    case ($urandom_range(9))
      0: return 8'($urandom_range(8'h7f));
      1: return 8'h80 | 8'($urandom_range(15));
      2: return 8'h90 | 8'($urandom_range(15));
      3: return 8'ha0 | 8'($urandom_range(15));
      4: return 8'hb0 | 8'($urandom_range(15));
      5: return 8'hc0 | 8'($urandom_range(15));
      6: return 8'hd0 | 8'($urandom_range(15));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_frame();
    int n;
    n = $urandom_range(3) == 0 ? $urandom_range(1, 3) : 0;
    if ($urandom_range(2) != 0)
      send(CMD_BEGIN, 4'($urandom), 32'h80000000 | 24'($urandom), 8'($urandom));
    else
      send(CMD_BEGIN, 4'($urandom), {8'h81, 8'(n), 16'($urandom)}, 8'($urandom));
    while (sb.active && sent < 750) begin
      if ($urandom_range(19) == 0) send(CMD_WRITE, 4'($urandom), $urandom, 8'($urandom));
      op(rand_opcode());
      drain_pop();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    send(CMD_SUPPLY, 4'd0, 32'hffffffff, 8'hff);
    op(8'h00);
    send(CMD_WRITE, 4'd13, 32'h00001000, 8'h00);
    send(CMD_WRITE, 4'd14, 32'hdeadbeef, 8'h00);
    send(CMD_BEGIN, 4'd15, 32'h7fffffff, 8'h00);
    send(CMD_BEGIN, 4'd15, 32'h80ffffff, 8'h00);
    op(8'h3f); op(8'h7f); op(8'hb0);
    send(CMD_BEGIN, 4'd13, 32'h81ff0000, 8'h00);
    op(8'hbf); op(8'hd7); op(8'h9d); op(8'h9f); op(8'h9e);
    op(8'hb2); op(8'hff);
    op(8'hc9); op(8'hff); op(8'h80); op(8'h00);
    send(CMD_BEGIN, 4'd4, 32'h80000000, 8'h00);
    op(8'haf); drain_pop(); op(8'h8f); op(8'hff); drain_pop();
    send(CMD_BEGIN, 4'd1, 32'h80000000, 8'h00);
    op(8'hb1); op(8'h0f); drain_pop(); op(8'hb1); op(8'h10);
    send(CMD_BEGIN, 4'd0, 32'h80000000, 8'h00);
    op(8'hb3); op(8'hff); op(8'hc8);
    send(CMD_BEGIN, 4'd0, 32'h80000000, 8'h00);
    op(8'hc8); op(8'h00); op(8'h82); op(8'h00); op(8'h00); drain_pop();
    send(CMD_BEGIN, 4'd0, 32'h80000000, 8'h00);
    op(8'hb4); op(8'hc0); op(8'hd8);
    quiesce();
    // random, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 84 : 0;
      snk_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 24 : 0;
      while (sent < 250 * (ph + 1)) begin
        if ($urandom_range(9) == 0)
          send(2'($urandom), 4'($urandom), $urandom, 8'($urandom));
        else random_frame();
      end
      quiesce();
    end
    quiesce();
    if (sb.expected_q.size() == 0 && sb.mismatches == 0)
      $display("ehabi_unwind_bytecode_engine_tb: clean");
    else
      $display("ehabi_unwind_bytecode_engine_tb: errors");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/eue_pkg.sv
rtl/core/eue_stream_if.sv
rtl/core/eue_exec.sv
rtl/core/ehabi_unwind_bytecode_engine.sv
test/ehabi_unwind_bytecode_engine_tb.sv
